// File: src/stt_pkg.sv
// Shared types and constants for the software timer table.
`default_nettype none

package stt_pkg;

    localparam logic [2:0] ACT_TICK         = 3'd0;
    localparam logic [2:0] ACT_ADD_PERIODIC = 3'd1;
    localparam logic [2:0] ACT_ADD_ONE_SHOT = 3'd2;
    localparam logic [2:0] ACT_REMOVE       = 3'd3;
    localparam logic [2:0] ACT_RESCHEDULE   = 3'd4;

    localparam logic [31:0] NONE_PENDING  = 32'hFFFF_FFFF;
    localparam logic [31:0] MILLI_RESET   = 32'd1;
    localparam logic [31:0] SECONDS_RESET = 32'd1;
    localparam logic [15:0] TPS_RESET     = 16'd1000;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [31:0] delay_ms;
    } stt_op_t;

    typedef struct packed {
        logic [15:0] fired_mask;
        logic [31:0] now_millis;
        logic [31:0] por_seconds;
        logic [31:0] next_deadline;
        logic        removed;
    } stt_result_t;

endpackage

`default_nettype wire

// File: src/stt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module stt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/stt_clock.sv
// Millisecond and seconds counters with the ticks-per-second register.
`default_nettype none

module stt_clock
    import stt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [15:0] cfg_data,
    input  wire logic        tick,
    output logic      [31:0] milli,
    output logic      [31:0] milli_inc,
    output logic      [31:0] seconds
);

    logic [15:0] tps_reg;
    logic [31:0] milli_reg;
    logic [15:0] tis_reg;
    logic [15:0] tis_inc;
    logic [31:0] sec_reg;

    assign milli_inc = milli_reg + 32'd1;
    assign tis_inc   = tis_reg + 16'd1;
    assign milli     = milli_reg;
    assign seconds   = sec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg   <= TPS_RESET;
            milli_reg <= MILLI_RESET;
            tis_reg   <= 16'd0;
            sec_reg   <= SECONDS_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                tps_reg <= cfg_data;
            end
            if (tick)
            begin
                milli_reg <= milli_inc;
                if (tis_inc >= tps_reg)
                begin
                    tis_reg <= 16'd0;
                    sec_reg <= sec_reg + 32'd1;
                end
                else
                begin
                    tis_reg <= tis_inc;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: src/software_timer_table_core.sv
// Top level of the software timer table: command sequencer and slot walk.
//
// Usage: drive op and raise start; the op beat is taken at an edge where
// start is high and busy is low. busy stays high until the result beat has
// been shown. The result beat is on result for exactly one cycle, marked by
// done; the receiver cannot stall it and must take it in that cycle.
// The ticks_per_second register is written through cfg_valid/cfg_data
// (cfg_ready is always high); the user must write it only while the
// block is idle, which the block itself leaves unenforced.
// An op that leaves the table alone (tick before the earliest deadline,
// unused action, slot outside the table, remove of an inactive slot) goes
// from EXEC straight to DONE. Any other op walks every slot through the
// single read port of the deadline and period memories, one slot per
// cycle plus a two-stage compare pipe, before DONE.
// Reset: no slot active, millisecond and seconds counters at one, next
// deadline all ones, ticks_per_second at 1000. The slot memories need no
// clearing: only the entries of active slots are used, and add writes both entries.
`default_nettype none

module software_timer_table_core
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire stt_op_t     op,
    output logic             done,
    output stt_result_t      result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);
    localparam logic [6:0] SLOTS_EXT = 7'(TIMER_SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [2:0]  act_reg;
    logic [3:0]  slot_reg;
    logic [31:0] delay_reg;

    logic [TIMER_SLOTS-1:0] active_reg;
    logic [TIMER_SLOTS-1:0] one_shot_reg;
    logic [TIMER_SLOTS-1:0] trig_reg;

    logic [15:0] fired_reg;
    logic        removed_reg;
    logic [31:0] earliest_reg;
    logic [31:0] best_reg;

    logic [SLOT_W-1:0] rd_idx_reg;
    logic              issuing_reg;
    logic              s1_valid_reg;
    logic [SLOT_W-1:0] s1_idx_reg;
    logic              s1_last_reg;
    logic              s2_valid_reg;
    logic              s2_pend_reg;
    logic              s2_last_reg;
    logic [31:0]       s2_dl_reg;

    logic [31:0] milli;
    logic [31:0] milli_inc;
    logic [31:0] seconds;

    logic              in_table;
    logic [SLOT_W-1:0] slot_idx;
    logic              is_tick;
    logic              exec_tick;

    logic [31:0]       dl_rdata;
    logic [31:0]       per_rdata;
    logic              dl_wr_en;
    logic [SLOT_W-1:0] dl_wr_addr;
    logic [31:0]       dl_wr_data;
    logic              per_wr_en;
    logic              rd_en;

    logic        s1_pend;
    logic        s1_fire;
    logic        s1_trig_new;
    logic [31:0] s1_dl_new;
    logic [6:0]  s1_idx_ext;
    logic [31:0] best_upd;

    assign in_table  = 7'(slot_reg) < SLOTS_EXT;
    assign slot_idx  = SLOT_W'(slot_reg);
    assign is_tick   = act_reg == ACT_TICK;
    assign exec_tick = (state_reg == ST_EXEC) && is_tick;
    assign busy      = state_reg != ST_IDLE;
    assign done      = state_reg == ST_DONE;
    assign cfg_ready = 1'b1;
    assign rd_en     = (state_reg == ST_WALK) && issuing_reg;

    stt_clock u_clock (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .tick      (exec_tick),
        .milli     (milli),
        .milli_inc (milli_inc),
        .seconds   (seconds)
    );

    // slot walk, stage one: fire decision and deadline reload
    assign s1_pend     = active_reg[s1_idx_reg] && !trig_reg[s1_idx_reg];
    assign s1_fire     = s1_valid_reg && is_tick && s1_pend && (dl_rdata <= milli);
    assign s1_trig_new = trig_reg[s1_idx_reg] || (s1_fire && one_shot_reg[s1_idx_reg]);
    assign s1_dl_new   = (s1_fire && !one_shot_reg[s1_idx_reg]) ? milli + per_rdata
                                                                : dl_rdata;
    assign s1_idx_ext  = 7'(s1_idx_reg);

    // slot walk, stage two: running minimum
    assign best_upd = (s2_valid_reg && s2_pend_reg && (s2_dl_reg < best_reg)) ? s2_dl_reg
                                                                              : best_reg;

    always_comb
    begin
        dl_wr_en   = 1'b0;
        dl_wr_addr = s1_idx_reg;
        dl_wr_data = s1_dl_new;
        per_wr_en  = 1'b0;
        if (state_reg == ST_EXEC)
        begin
            dl_wr_addr = slot_idx;
            dl_wr_data = milli + delay_reg;
            if (in_table && ((act_reg == ACT_ADD_PERIODIC) || (act_reg == ACT_ADD_ONE_SHOT)
                             || (act_reg == ACT_RESCHEDULE)))
            begin
                dl_wr_en = 1'b1;
            end
            if (in_table && ((act_reg == ACT_ADD_PERIODIC) || (act_reg == ACT_ADD_ONE_SHOT)))
            begin
                per_wr_en = 1'b1;
            end
        end
        else if (s1_fire && !one_shot_reg[s1_idx_reg])
        begin
            dl_wr_en = 1'b1;
        end
    end

    stt_ram #(
        .WIDTH (32),
        .DEPTH (TIMER_SLOTS)
    ) u_deadline_ram (
        .clk     (clk),
        .wr_en   (dl_wr_en),
        .wr_addr (dl_wr_addr),
        .wr_data (dl_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (dl_rdata)
    );

    stt_ram #(
        .WIDTH (32),
        .DEPTH (TIMER_SLOTS)
    ) u_period_ram (
        .clk     (clk),
        .wr_en   (per_wr_en),
        .wr_addr (slot_idx),
        .wr_data (delay_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (per_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (act_reg)
                    ACT_TICK:
                    begin
                        if (milli_inc >= earliest_reg)
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    ACT_ADD_PERIODIC, ACT_ADD_ONE_SHOT, ACT_RESCHEDULE:
                    begin
                        if (in_table)
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (in_table && active_reg[slot_idx])
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WALK:
            begin
                if (s2_valid_reg && s2_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            active_reg   <= '0;
            one_shot_reg <= '0;
            trig_reg     <= '0;
            fired_reg    <= '0;
            removed_reg  <= 1'b0;
            earliest_reg <= NONE_PENDING;
            best_reg     <= NONE_PENDING;
            rd_idx_reg   <= '0;
            issuing_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= rd_en;
            s1_last_reg  <= rd_idx_reg == LAST_SLOT;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;

            if ((state_reg == ST_IDLE) && start)
            begin
                fired_reg   <= '0;
                removed_reg <= 1'b0;
            end

            if (state_reg == ST_EXEC)
            begin
                rd_idx_reg  <= '0;
                issuing_reg <= 1'b1;
                best_reg    <= NONE_PENDING;
                if (in_table)
                begin
                    case (act_reg)
                        ACT_ADD_PERIODIC, ACT_ADD_ONE_SHOT:
                        begin
                            active_reg[slot_idx]   <= 1'b1;
                            one_shot_reg[slot_idx] <= act_reg == ACT_ADD_ONE_SHOT;
                            trig_reg[slot_idx]     <= 1'b0;
                        end
                        ACT_REMOVE:
                        begin
                            if (active_reg[slot_idx])
                            begin
                                active_reg[slot_idx] <= 1'b0;
                                trig_reg[slot_idx]   <= 1'b1;
                                removed_reg          <= 1'b1;
                            end
                        end
                        ACT_RESCHEDULE:
                        begin
                            trig_reg[slot_idx] <= 1'b0;
                        end
                        default:
                        begin
                            trig_reg <= trig_reg;
                        end
                    endcase
                end
            end

            if (rd_en)
            begin
                if (rd_idx_reg == LAST_SLOT)
                begin
                    issuing_reg <= 1'b0;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + SLOT_W'(1);
                end
            end

            if (s1_valid_reg)
            begin
                trig_reg[s1_idx_reg] <= s1_trig_new;
            end
            if (s1_fire && (s1_idx_ext < 7'd16))
            begin
                fired_reg[s1_idx_ext[3:0]] <= 1'b1;
            end

            if (s2_valid_reg)
            begin
                best_reg <= best_upd;
                if (s2_last_reg)
                begin
                    earliest_reg <= best_upd;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            act_reg   <= op.action;
            slot_reg  <= op.slot;
            delay_reg <= op.delay_ms;
        end
        s1_idx_reg  <= rd_idx_reg;
        s2_pend_reg <= active_reg[s1_idx_reg] && !s1_trig_new;
        s2_dl_reg   <= s1_dl_new;
    end

    assign result.fired_mask    = fired_reg;
    assign result.now_millis    = milli;
    assign result.por_seconds   = seconds;
    assign result.next_deadline = earliest_reg;
    assign result.removed       = removed_reg;

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted op did not raise busy");

    a_fired_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.fired_mask != 16'd0)) |-> (act_reg == ACT_TICK))
        else $error("slots fired on a non-tick op");

    a_removed_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.removed) |-> (act_reg == ACT_REMOVE))
        else $error("removed flag on a non-remove op");

endmodule

`default_nettype wire

// File: verif/software_timer_table_core_tb.sv
// Self-checking testbench for software_timer_table_core: scoreboard predicts every result beat.
`timescale 1ns / 100ps

module software_timer_table_core_tb;
    import stt_pkg::*;

    localparam int TIMER_SLOTS = 16;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PHASES = 6;
    localparam int DRAIN_CYCLES = 40;

    class timer_table_sb;
        stt_result_t timer_reports_q[$];
        int errors;
        bit slot_on[TIMER_SLOTS];
        bit slot_single[TIMER_SLOTS];
        bit slot_spent[TIMER_SLOTS];
        logic [31:0] slot_due[TIMER_SLOTS];
        logic [31:0] slot_every[TIMER_SLOTS];
        logic [31:0] millis;
        logic [31:0] seconds;
        logic [31:0] soonest;
        logic [15:0] ticks_in_sec;
        logic [15:0] tps;

        function new();
            errors = 0;
            millis = MILLI_RESET;
            seconds = SECONDS_RESET;
            soonest = NONE_PENDING;
            ticks_in_sec = '0;
            tps = TPS_RESET;
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                slot_on[i] = 1'b0;
                slot_single[i] = 1'b0;
                slot_spent[i] = 1'b0;
                slot_due[i] = '0;
                slot_every[i] = '0;
            end
        endfunction

        function void set_tps(logic [15:0] value);
            tps = value;
        endfunction

        function logic [31:0] soonest_pending();
            logic [31:0] best;
            best = NONE_PENDING;
            for (int i = 0; i < TIMER_SLOTS; i++)
                if (slot_on[i] && !slot_spent[i] && slot_due[i] < best)
                    best = slot_due[i];
            return best;
        endfunction

        function void apply_op(stt_op_t o);
            stt_result_t rep;
            rep = '0;
            case (o.action)
                ACT_TICK:
                begin
                    millis = millis + 32'd1;
                    ticks_in_sec = ticks_in_sec + 16'd1;
                    if (millis >= soonest)
                    begin
                        for (int i = 0; i < TIMER_SLOTS; i++)
                        begin
                            if (slot_on[i] && !slot_spent[i] && slot_due[i] <= millis)
                            begin
                                rep.fired_mask[i] = 1'b1;
                                if (slot_single[i])
                                    slot_spent[i] = 1'b1;
                                else
                                    slot_due[i] = millis + slot_every[i];
                            end
                        end
                        soonest = soonest_pending();
                    end
                    if (ticks_in_sec >= tps)
                    begin
                        ticks_in_sec = '0;
                        seconds = seconds + 32'd1;
                    end
                end
                ACT_ADD_PERIODIC, ACT_ADD_ONE_SHOT:
                begin
                    slot_due[o.slot] = millis + o.delay_ms;
                    slot_every[o.slot] = o.delay_ms;
                    slot_single[o.slot] = (o.action == ACT_ADD_ONE_SHOT);
                    slot_spent[o.slot] = 1'b0;
                    slot_on[o.slot] = 1'b1;
                    soonest = soonest_pending();
                end
                ACT_REMOVE:
                begin
                    if (slot_on[o.slot])
                    begin
                        slot_on[o.slot] = 1'b0;
                        slot_spent[o.slot] = 1'b1;
                        rep.removed = 1'b1;
                        soonest = soonest_pending();
                    end
                end
                ACT_RESCHEDULE:
                begin
                    slot_due[o.slot] = millis + o.delay_ms;
                    slot_spent[o.slot] = 1'b0;
                    soonest = soonest_pending();
                end
                default:
                begin
                end
            endcase
            rep.now_millis = millis;
            rep.por_seconds = seconds;
            rep.next_deadline = soonest;
            timer_reports_q.push_back(rep);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= 10)
                    $display("%s mismatch: expected %h, actual %h", name, want, got);
            end
        endfunction

        function void check_report(stt_result_t got);
            stt_result_t want;
            if (timer_reports_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result beat with nothing pending: %p", got);
                return;
            end
            want = timer_reports_q.pop_front();
            check_field("fired_mask", 32'(want.fired_mask), 32'(got.fired_mask));
            check_field("now_millis", want.now_millis, got.now_millis);
            check_field("por_seconds", want.por_seconds, got.por_seconds);
            check_field("next_deadline", want.next_deadline, got.next_deadline);
            check_field("removed", 32'(want.removed), 32'(got.removed));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    stt_op_t op;
    logic done;
    stt_result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [15:0] cfg_data;

    timer_table_sb sb = new();

    software_timer_table_core #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_report(result);

    task automatic send_op(input logic [2:0] action, input logic [3:0] slot,
                           input logic [31:0] delay_ms);
        stt_op_t o;
        o.action = action;
        o.slot = slot;
        o.delay_ms = delay_ms;
        start <= 1'b1;
        op <= o;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.apply_op(o);
    endtask

    // wait until every result beat is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.timer_reports_q.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_tps(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_tps(value);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] tps_plan[PHASES];
        logic [2:0] act;
        logic [31:0] dly;
        int sel;
        int counted;
        int burst_left;

        rst_n <= 1'b0;
        start <= 1'b0;
        op <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= TPS_RESET;
        tps_plan = '{16'hFFFF, 16'd3, 16'd1, 16'd0, 16'd0, TPS_RESET};
        tps_plan[4] = 16'($urandom_range(1, 65535));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_op(ACT_TICK, 4'd0, 32'd0);
        send_op(ACT_ADD_PERIODIC, 4'd0, 32'd2);
        send_op(ACT_ADD_ONE_SHOT, 4'd15, 32'd0);
        send_op(ACT_TICK, 4'd15, 32'hFFFF_FFFF);
        send_op(ACT_TICK, 4'd0, 32'd0);
        send_op(ACT_TICK, 4'd0, 32'd0);
        send_op(ACT_REMOVE, 4'd0, 32'd0);
        send_op(ACT_REMOVE, 4'd0, 32'd0);
        send_op(ACT_RESCHEDULE, 4'd15, 32'd1);
        send_op(ACT_TICK, 4'd0, 32'd0);
        send_op(ACT_TICK, 4'd0, 32'd0);
        send_op(ACT_RESCHEDULE, 4'd7, 32'd0);
        send_op(ACT_TICK, 4'd0, 32'd0);
        send_op(ACT_ADD_PERIODIC, 4'd3, 32'hFFFF_FFFF);
        send_op(ACT_TICK, 4'd0, 32'd0);
        send_op(ACT_ADD_ONE_SHOT, 4'd5, 32'hFFFF_FFFE);
        send_op(3'd5, 4'd15, 32'hFFFF_FFFF);
        send_op(3'd6, 4'd0, 32'd0);
        send_op(3'd7, 4'd15, 32'hFFFF_FFFF);
        send_op(ACT_ADD_PERIODIC, 4'd10, 32'd0);
        send_op(ACT_TICK, 4'd0, 32'd0);
        send_op(ACT_ADD_ONE_SHOT, 4'd10, 32'd5);
        send_op(ACT_TICK, 4'd0, 32'd0);
        send_op(ACT_REMOVE, 4'd3, 32'd0);
        send_op(ACT_REMOVE, 4'd15, 32'd0);

        burst_left = $urandom_range(1, 24);
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_tps(tps_plan[p]);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    dly = $urandom_range(0, 20);
                else if (sel < 85)
                    dly = $urandom_range(21, 300);
                else if (sel < 95)
                    dly = $urandom;
                else
                begin
                    case ($urandom_range(0, 2))
                        0: dly = 32'd0;
                        1: dly = 32'hFFFF_FFFF;
                        default: dly = 32'hFFFF_FFFE;
                    endcase
                end
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    act = ACT_TICK;
                else if (sel < 67)
                    act = ACT_ADD_PERIODIC;
                else if (sel < 79)
                    act = ACT_ADD_ONE_SHOT;
                else if (sel < 88)
                    act = ACT_REMOVE;
                else if (sel < 96)
                    act = ACT_RESCHEDULE;
                else
                    act = 3'($urandom_range(5, 7));
                send_op(act, 4'($urandom_range(0, 15)), dly);
                if (act <= ACT_RESCHEDULE)
                    counted++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                    burst_left = $urandom_range(1, 24);
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.timer_reports_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #500000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
src/stt_pkg.sv
src/stt_ram.sv
src/stt_clock.sv
src/software_timer_table_core.sv
verif/software_timer_table_core_tb.sv
